[sv/qrs_pkg.sv]
// Package for the quadratic root solver: widths, count codes, CSR map and the
// side-band types that travel with each item down the pipeline. No dependencies.
`timescale 1ns / 1ps
package qrs_pkg;

   localparam int COEFF_W       = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int TOL_W         = 16;
   localparam int DISC_W        = 67;   // signed b*b - 4ac
   localparam int SQ_N          = 33;   // root bits of a 66-bit radicand
   localparam int ROOT_W        = 33;
   localparam int REM_W         = 36;
   localparam int NUM_W         = 34;   // numerator magnitude
   localparam int DIV_W         = 33;   // divisor magnitude
   localparam int CSR_AW        = 3;
   localparam int CSR_DW        = 32;

   localparam logic [CSR_AW-1:0] ADDR_TOL = 3'd0;

   localparam logic [1:0] CNT_NONE = 2'd0;
   localparam logic [1:0] CNT_ONE  = 2'd1;
   localparam logic [1:0] CNT_TWO  = 2'd2;
   localparam logic [1:0] CNT_INF  = 2'd3;

   typedef struct packed {
      logic                    valid;
      logic [1:0]              count;
      logic signed [NUM_W-1:0] nb;
      logic [DIV_W-1:0]        dm;
      logic                    dsg;
   } sq_side_type;

   typedef struct packed {
      logic             valid;
      logic [1:0]       count;
      logic             neg1;
      logic             neg2;
      logic [DIV_W-1:0] dm;
   } dv_side_type;

endpackage

[sv/quadratic_root_solver.sv]
// Quadratic root solver top level: products, discriminant, pipelined square
// root and two pipelined restoring dividers. Depends on qrs_pkg.
//
//  channel | ports                                    | handshake
//  --------+------------------------------------------+------------------------
//  request | start, busy, req_coeff_a/b/c, linear_only | start & !busy
//  result  | rsp_strobe, rsp_root_*, rsp_saturated    | one-cycle strobe
//  csr     | psel, penable, pwrite, paddr, pwdata     | APB, pready tied high
//
// One item per cycle; busy is never raised. 33 square root stages plus
// 34 + FRAC_BITS divider stages set the depth. Synchronous reset clears
// valid bits and sets tolerance to 1. The receiver cannot stall, so the
// pipeline always advances.
`timescale 1ns / 1ps
module quadratic_root_solver #(
   parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [qrs_pkg::COEFF_W-1:0]  req_coeff_a,
   input  logic signed [qrs_pkg::COEFF_W-1:0]  req_coeff_b,
   input  logic signed [qrs_pkg::COEFF_W-1:0]  req_coeff_c,
   input  logic                                req_linear_only,
   output logic                                rsp_strobe,
   output logic [1:0]                          rsp_root_count,
   output logic signed [qrs_pkg::COEFF_W-1:0]  rsp_root_first,
   output logic signed [qrs_pkg::COEFF_W-1:0]  rsp_root_second,
   output logic                                rsp_saturated,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [qrs_pkg::CSR_AW-1:0]          paddr,
   input  logic [qrs_pkg::CSR_DW-1:0]          pwdata,
   output logic [qrs_pkg::CSR_DW-1:0]          prdata,
   output logic                                pready
);
   import qrs_pkg::*;

   localparam int QW = NUM_W + FRAC_BITS;

   // csr
   logic [TOL_W-1:0] tol_ff;

   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign prdata = (paddr == ADDR_TOL) ? CSR_DW'(tol_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_W'(1);
      end else if (psel && penable && pwrite && pready && paddr == ADDR_TOL) begin
         tol_ff <= pwdata[TOL_W-1:0];
      end
   end

   // stage 0: input register
   logic                      s0_vld_ff, s0_lin_ff;
   logic signed [COEFF_W-1:0] s0_a_ff, s0_b_ff, s0_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= start && !busy;
      end
      s0_a_ff   <= req_coeff_a;
      s0_b_ff   <= req_coeff_b;
      s0_c_ff   <= req_coeff_c;
      s0_lin_ff <= req_linear_only;
   end

   // stage 1: products
   logic                        s1_vld_ff, s1_lin_ff;
   logic signed [2*COEFF_W-1:0] s1_bb_ff, s1_ac_ff;
   logic signed [COEFF_W-1:0]   s1_b_ff, s1_c_ff;
   logic signed [COEFF_W:0]     s1_a2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s0_vld_ff;
      end
      s1_bb_ff  <= s0_b_ff * s0_b_ff;
      s1_ac_ff  <= s0_a_ff * s0_c_ff;
      s1_lin_ff <= s0_lin_ff || (s0_a_ff == '0);
      s1_b_ff   <= s0_b_ff;
      s1_c_ff   <= s0_c_ff;
      s1_a2_ff  <= {s0_a_ff, 1'b0};
   end

   // stage 2: discriminant
   logic                      s2_vld_ff, s2_lin_ff;
   logic signed [DISC_W-1:0]  s2_d_ff;
   logic signed [COEFF_W-1:0] s2_b_ff, s2_c_ff;
   logic signed [COEFF_W:0]   s2_a2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_d_ff   <= DISC_W'(s1_bb_ff) - (DISC_W'(s1_ac_ff) <<< 2);
      s2_lin_ff <= s1_lin_ff;
      s2_b_ff   <= s1_b_ff;
      s2_c_ff   <= s1_c_ff;
      s2_a2_ff  <= s1_a2_ff;
   end

   // square root pipeline, entry is classification
   logic [DISC_W-2:0] sq_d_ff    [0:SQ_N];
   logic [REM_W-1:0]  sq_rem_ff  [0:SQ_N];
   logic [ROOT_W-1:0] sq_root_ff [0:SQ_N];
   sq_side_type       sq_side_ff [0:SQ_N];
   sq_side_type       sq_side_in;

   logic signed [DISC_W-1:0] thr;
   logic signed [COEFF_W:0]  dv_sel;
   logic                     near;

   always_comb begin
      thr    = $signed({{(DISC_W-TOL_W-FRAC_BITS){1'b0}}, tol_ff, {FRAC_BITS{1'b0}}});
      near   = (s2_d_ff == '0) || ((s2_d_ff < thr) && (s2_d_ff > -thr));
      dv_sel = s2_lin_ff ? (COEFF_W+1)'(s2_b_ff) : s2_a2_ff;
      sq_side_in.valid = s2_vld_ff;
      sq_side_in.dsg   = dv_sel[COEFF_W];
      sq_side_in.dm    = dv_sel[COEFF_W] ? DIV_W'(-dv_sel) : DIV_W'(dv_sel);
      sq_side_in.nb    = s2_lin_ff ? -NUM_W'(s2_c_ff) : -NUM_W'(s2_b_ff);
      if (s2_lin_ff) begin
         if (s2_b_ff != '0) begin
            sq_side_in.count = CNT_ONE;
         end else begin
            sq_side_in.count = (s2_c_ff == '0) ? CNT_INF : CNT_NONE;
         end
      end else if (near) begin
         sq_side_in.count = CNT_ONE;
      end else begin
         sq_side_in.count = s2_d_ff[DISC_W-1] ? CNT_NONE : CNT_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_side_ff[0].valid <= 1'b0;
      end else begin
         sq_side_ff[0] <= sq_side_in;
      end
      sq_d_ff[0]    <= s2_d_ff[DISC_W-2:0];
      sq_rem_ff[0]  <= '0;
      sq_root_ff[0] <= '0;
   end

   for (genvar k = 0; k < SQ_N; k++) begin : g_sq
      logic [REM_W-1:0]  rs, trial;
      logic [ROOT_W-1:0] rts;
      logic              ge;

      always_comb begin
         rs    = {sq_rem_ff[k][REM_W-3:0], sq_d_ff[k][DISC_W-2:DISC_W-3]};
         rts   = {sq_root_ff[k][ROOT_W-2:0], 1'b0};
         trial = REM_W'({rts, 1'b1});
         ge    = (rs >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_side_ff[k+1].valid <= 1'b0;
         end else begin
            sq_side_ff[k+1] <= sq_side_ff[k];
         end
         sq_d_ff[k+1]    <= {sq_d_ff[k][DISC_W-4:0], 2'b00};
         sq_rem_ff[k+1]  <= ge ? (rs - trial) : rs;
         sq_root_ff[k+1] <= ge ? (rts | ROOT_W'(1)) : rts;
      end
   end

   // divider pipeline, entry forms the numerators
   logic [QW-1:0]    dv_q1_ff   [0:QW];
   logic [QW-1:0]    dv_q2_ff   [0:QW];
   logic [DIV_W-1:0] dv_r1_ff   [0:QW];
   logic [DIV_W-1:0] dv_r2_ff   [0:QW];
   dv_side_type      dv_side_ff [0:QW];
   dv_side_type      dv_side_in;

   logic signed [NUM_W:0] n1, n2, sx;
   sq_side_type           sq_last;

   always_comb begin
      sq_last = sq_side_ff[SQ_N];
      sx      = $signed({2'b00, sq_root_ff[SQ_N]});
      n1      = (NUM_W+1)'(sq_last.nb) + ((sq_last.count == CNT_TWO) ? sx : '0);
      n2      = (NUM_W+1)'(sq_last.nb) - sx;
      dv_side_in.valid = sq_last.valid;
      dv_side_in.count = sq_last.count;
      dv_side_in.dm    = sq_last.dm;
      dv_side_in.neg1  = n1[NUM_W] ^ sq_last.dsg;
      dv_side_in.neg2  = n2[NUM_W] ^ sq_last.dsg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_side_ff[0].valid <= 1'b0;
      end else begin
         dv_side_ff[0] <= dv_side_in;
      end
      dv_q1_ff[0] <= {(n1[NUM_W] ? NUM_W'(-n1) : NUM_W'(n1)), {FRAC_BITS{1'b0}}};
      dv_q2_ff[0] <= {(n2[NUM_W] ? NUM_W'(-n2) : NUM_W'(n2)), {FRAC_BITS{1'b0}}};
      dv_r1_ff[0] <= '0;
      dv_r2_ff[0] <= '0;
   end

   for (genvar k = 0; k < QW; k++) begin : g_dv
      logic [DIV_W:0] t1, t2, dx;
      logic           ge1, ge2;

      always_comb begin
         dx  = {1'b0, dv_side_ff[k].dm};
         t1  = {dv_r1_ff[k], dv_q1_ff[k][QW-1]};
         t2  = {dv_r2_ff[k], dv_q2_ff[k][QW-1]};
         ge1 = (t1 >= dx);
         ge2 = (t2 >= dx);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_side_ff[k+1].valid <= 1'b0;
         end else begin
            dv_side_ff[k+1] <= dv_side_ff[k];
         end
         dv_r1_ff[k+1] <= ge1 ? DIV_W'(t1 - dx) : t1[DIV_W-1:0];
         dv_r2_ff[k+1] <= ge2 ? DIV_W'(t2 - dx) : t2[DIV_W-1:0];
         dv_q1_ff[k+1] <= {dv_q1_ff[k][QW-2:0], ge1};
         dv_q2_ff[k+1] <= {dv_q2_ff[k][QW-2:0], ge2};
      end
   end

   // saturate, sign and select
   function automatic logic [COEFF_W:0] clip(input logic [QW-1:0] q, input logic neg);
      logic [QW-1:0]      lim;
      logic [COEFF_W-1:0] v;
      logic               sat;
      lim = neg ? QW'(33'h0_8000_0000) : QW'(33'h0_7FFF_FFFF);
      sat = (q > lim);
      v   = sat ? lim[COEFF_W-1:0] : q[COEFF_W-1:0];
      v   = neg ? -v : v;
      return {sat, v};
   endfunction

   logic [COEFF_W:0] c1, c2;
   dv_side_type      dv_last;
   logic             out_vld_ff, out_sat_ff;
   logic [1:0]       out_cnt_ff;
   logic [COEFF_W-1:0] out_r1_ff, out_r2_ff;

   always_comb begin
      dv_last = dv_side_ff[QW];
      c1      = clip(dv_q1_ff[QW], dv_last.neg1);
      c2      = clip(dv_q2_ff[QW], dv_last.neg2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= dv_last.valid;
      end
      out_cnt_ff <= dv_last.count;
      case (dv_last.count)
         CNT_ONE: begin
            out_r1_ff  <= c1[COEFF_W-1:0];
            out_r2_ff  <= '0;
            out_sat_ff <= c1[COEFF_W];
         end
         CNT_TWO: begin
            out_r1_ff  <= c1[COEFF_W-1:0];
            out_r2_ff  <= c2[COEFF_W-1:0];
            out_sat_ff <= c1[COEFF_W] | c2[COEFF_W];
         end
         default: begin
            out_r1_ff  <= '0;
            out_r2_ff  <= '0;
            out_sat_ff <= 1'b0;
         end
      endcase
   end

   assign rsp_strobe      = out_vld_ff;
   assign rsp_root_count  = out_cnt_ff;
   assign rsp_root_first  = $signed(out_r1_ff);
   assign rsp_root_second = $signed(out_r2_ff);
   assign rsp_saturated   = out_sat_ff;

endmodule

[sv/qrs_checker.sv]
// Port-level checks for the quadratic root solver, bound to the top level.
// Depends on qrs_pkg and quadratic_root_solver.
`timescale 1ns / 1ps
module qrs_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               busy,
   input logic                               rsp_strobe,
   input logic [1:0]                         rsp_root_count,
   input logic signed [qrs_pkg::COEFF_W-1:0] rsp_root_first,
   input logic signed [qrs_pkg::COEFF_W-1:0] rsp_root_second,
   input logic                               rsp_saturated
);
   import qrs_pkg::*;

   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe after reset");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_root_count == CNT_NONE || rsp_root_count == CNT_INF) |->
      rsp_root_first == '0 && rsp_root_second == '0 && !rsp_saturated)
      else $error("roots given without a root");

   a_one_second: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_root_count == CNT_ONE |-> rsp_root_second == '0)
      else $error("second root with single root");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_root_count  (rsp_root_count),
   .rsp_root_first  (rsp_root_first),
   .rsp_root_second (rsp_root_second),
   .rsp_saturated   (rsp_saturated)
);

[dv/tb.sv]
// Testbench for quadratic_root_solver: directed and random equations, with a
// behavioural root predictor and an in-order result checker. Depends on qrs_pkg and quadratic_root_solver.
`timescale 1ns / 1ps
module tb;
   import qrs_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam int LATENCY = 72 + FB;
   localparam int WATCHDOG_LIMIT = 4 * LATENCY + 200;

   typedef struct {
      logic [1:0]  count;
      logic [31:0] first;
      logic [31:0] second;
      logic        sat;
   } roots_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_coeff_a = '0, req_coeff_b = '0, req_coeff_c = '0;
   logic req_linear_only = 1'b0;
   logic rsp_strobe;
   logic [1:0] rsp_root_count;
   logic signed [31:0] rsp_root_first, rsp_root_second;
   logic rsp_saturated;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic pready;

   roots_type expected_roots[$];
   logic [15:0] tol_model;
   int errors = 0;
   int idle_cycles = 0;
   bit gaps_on = 1'b1;

   always #5 clock = ~clock;

   quadratic_root_solver DUT (.*);

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   // Q-format quotient, truncated toward zero, clipped to 32 bits
   function automatic logic [31:0] q_divide(input logic signed [67:0] n,
                                            input logic signed [67:0] d, inout logic sat);
      logic [67:0] nm, dm, q, lim;
      logic neg;
      nm = n < 0 ? -n : n;
      dm = d < 0 ? -d : d;
      if (dm == 0) return '0;
      q = (nm << FB) / dm;
      neg = (n < 0) != (d < 0);
      lim = neg ? 68'h80000000 : 68'h7FFFFFFF;
      if (q > lim) begin
         q = lim;
         sat = 1'b1;
      end
      return neg ? 32'(-q) : q[31:0];
   endfunction

   function automatic logic [67:0] floor_sqrt(input logic [67:0] v);
      logic [67:0] rem, root, trial;
      rem = 0;
      root = 0;
      for (int i = 33; i >= 0; i--) begin
         rem = (rem << 2) | ((v >> (2 * i)) & 68'd3);
         root = root << 1;
         trial = (root << 1) | 68'd1;
         if (rem >= trial) begin
            rem -= trial;
            root |= 68'd1;
         end
      end
      return root;
   endfunction

   function automatic roots_type solve_roots(input logic signed [31:0] a, b, c,
                                             input logic lin);
      roots_type r;
      logic signed [67:0] disc, two_a, nb, s, absd;
      r = '{CNT_NONE, '0, '0, 1'b0};
      nb = -68'(b);
      if (lin || a == 0) begin
         if (b != 0) begin
            r.first = q_divide(-68'(c), 68'(b), r.sat);
            r.count = CNT_ONE;
         end else
            r.count = (c == 0) ? CNT_INF : CNT_NONE;
      end else begin
         disc = 68'(b) * 68'(b) - 68'sd4 * 68'(a) * 68'(c);
         two_a = 68'sd2 * 68'(a);
         absd = disc < 0 ? -disc : disc;
         if (disc == 0 || absd < (68'(tol_model) << FB)) begin
            r.first = q_divide(nb, two_a, r.sat);
            r.count = CNT_ONE;
         end else if (disc > 0) begin
            s = floor_sqrt(disc);
            r.first = q_divide(nb + s, two_a, r.sat);
            r.second = q_divide(nb - s, two_a, r.sat);
            r.count = CNT_TWO;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_roots.size() == 0) begin
            report("unexpected result", 32'(rsp_strobe), 32'd0);
         end else begin
            roots_type e;
            e = expected_roots.pop_front();
            if (rsp_root_count !== e.count) report("count", 32'(rsp_root_count), 32'(e.count));
            if (rsp_root_first !== e.first) report("first", rsp_root_first, e.first);
            if (rsp_root_second !== e.second) report("second", rsp_root_second, e.second);
            if (rsp_saturated !== e.sat) report("saturated", 32'(rsp_saturated), 32'(e.sat));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic send_equation(input logic signed [31:0] a, b, c, input logic lin);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      start <= 1'b1;
      req_coeff_a <= a;
      req_coeff_b <= b;
      req_coeff_c <= c;
      req_linear_only <= lin;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_roots.push_back(solve_roots(a, b, c, lin));
      @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (expected_roots.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   task automatic write_tolerance(input logic [15:0] v);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= ADDR_TOL;
      pwdata <= 32'(v);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      tol_model = v;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic logic [31:0] rand_coeff();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
         2: return 32'($signed($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000);
         3: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 7)
                                        : 32'h80000000 + $urandom_range(0, 7);
         default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      endcase
   endfunction

   task automatic test_directed();
      send_equation(32'h10000, 32'hFFFD0000, 32'h20000, 1'b0);  // two roots
      send_equation(32'h10000, 32'hFFFE0000, 32'h10000, 1'b0);  // double root
      send_equation(32'h10000, 32'h0, 32'h10000, 1'b0);          // no real roots
      send_equation(32'h0, 32'h20000, 32'h10000, 1'b0);          // a zero
      send_equation(32'h30000, 32'h20000, 32'h10000, 1'b1);      // linear flag
      send_equation(32'h0, 32'h0, 32'h0, 1'b0);                  // infinitely many
      send_equation(32'h0, 32'h0, 32'h5, 1'b1);                  // contradiction
      send_equation(32'h1, 32'h7FFFFFFF, 32'h80000000, 1'b0);    // saturation
      send_equation(32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
      send_equation(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
      send_equation(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
      send_equation(32'hFFFFFFFF, 32'h1, 32'h1, 1'b0);
      send_equation(32'h0, 32'h1, 32'h80000000, 1'b0);
      send_equation(32'h0, 32'h80000000, 32'h7FFFFFFF, 1'b1);
      send_equation(32'h100, 32'h200, 32'h100, 1'b0);            // tiny, near zero D
      send_equation(32'h1, 32'h3, 32'h2, 1'b0);
      drain_results();
   endtask

   task automatic test_tolerance_band(input logic [15:0] tol, input int n);
      logic signed [31:0] a, b;
      write_tolerance(tol);
      for (int i = 0; i < n; i++) begin
         a = 32'($signed($urandom_range(1, 16'hFFFF)));
         if ($urandom_range(0, 1)) a = -a;
         b = 32'($signed($urandom_range(0, 32'h3FFFF))) - 32'sh20000;
         // c near b*b/4a so that D falls near the band
         send_equation(a, b, 32'(((64'(b) * 64'(b)) / (4 * 64'(a))))
                       + 32'($signed($urandom_range(0, 6)) - 3), 1'b0);
      end
      drain_results();
   endtask

   task automatic test_random(input int n);
      for (int i = 0; i < n; i++)
         send_equation(rand_coeff(), rand_coeff(), rand_coeff(),
                       $urandom_range(0, 7) == 0);
   endtask

   initial begin
      tol_model = 16'd1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_tolerance_band(16'd0, 40);
      test_tolerance_band(16'hFFFF, 40);
      test_tolerance_band(16'd100, 40);
      write_tolerance(16'($urandom));
      test_random(500);
      drain_results();
      test_tolerance_band(16'd1, 30);
      gaps_on = 1'b0;
      test_random(480);
      drain_results();
      if (errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end
endmodule

[sim.f]
sv/qrs_pkg.sv
sv/quadratic_root_solver.sv
sv/qrs_checker.sv
dv/tb.sv
